### rtl/core/kbrl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbrl_pkg
// Shared types and constants for the karma byte-rate limiter.
// ----------------------------------------------------------------------------
package kbrl_pkg;

    localparam int KARMA_W = 11;
    localparam int STEP_W  = 10;
    localparam int BPK_W   = 16;
    localparam int METER_W = 32;
    localparam int TIME_W  = 32;
    localparam int BYTES_W = 16;
    localparam int MAG_W   = KARMA_W;
    localparam int ALLOW_W = MAG_W + BPK_W;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    typedef enum logic [2:0] {
        REG_INITIAL_KARMA  = 3'd0,
        REG_MAX_KARMA      = 3'd1,
        REG_INC_STEP       = 3'd2,
        REG_DEC_STEP       = 3'd3,
        REG_PENALTY_VALUE  = 3'd4,
        REG_RESTORE_VALUE  = 3'd5,
        REG_RESET_METER_EN = 3'd6,
        REG_BYTES_PER_KARMA = 3'd7
    } kbrl_reg_t;

    localparam logic signed [KARMA_W-1:0] RST_INITIAL_KARMA = 11'sd5;
    localparam logic signed [KARMA_W-1:0] RST_MAX_KARMA     = 11'sd10;
    localparam logic [STEP_W-1:0]         RST_INC_STEP      = 10'd1;
    localparam logic [STEP_W-1:0]         RST_DEC_STEP      = 10'd0;
    localparam logic signed [KARMA_W-1:0] RST_PENALTY_VALUE = -11'sd5;
    localparam logic signed [KARMA_W-1:0] RST_RESTORE_VALUE = 11'sd5;
    localparam logic [BPK_W-1:0]          RST_BYTES_PER_KARMA = 16'd100;

    typedef struct packed {
        logic signed [KARMA_W-1:0] max_karma;
        logic [STEP_W-1:0]         inc_step;
        logic [STEP_W-1:0]         dec_step;
        logic signed [KARMA_W-1:0] penalty_value;
        logic signed [KARMA_W-1:0] restore_value;
        logic                      reset_meter_en;
        logic [BPK_W-1:0]          bytes_per_karma;
    } kbrl_cfg_t;

    typedef struct packed {
        logic signed [KARMA_W-1:0] karma;
        logic [METER_W-1:0]        meter;
        logic [TIME_W-1:0]         last_credit;
    } kbrl_state_t;

    function automatic logic [MAG_W-1:0] karma_mag(input logic signed [KARMA_W-1:0] k);
        logic [MAG_W-1:0] u;
        u = k;
        return k[KARMA_W-1] ? (~u + MAG_W'(1)) : u;
    endfunction

endpackage
`default_nettype wire

### rtl/core/kbrl_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbrl_update
// One read event: heartbeat credit followed by the byte charge.
// ----------------------------------------------------------------------------
module kbrl_update import kbrl_pkg::*; #(
    parameter int HEARTBEAT_SECONDS = 2
) (
    input  kbrl_cfg_t            cfg,
    input  logic [ALLOW_W-1:0]   restore_allow,
    input  kbrl_state_t          cur,
    input  logic [TIME_W-1:0]    now_seconds,
    input  logic [BYTES_W-1:0]   byte_count,
    output kbrl_state_t          nxt,
    output logic                 over_limit
);

    localparam logic [TIME_W:0] HB = (TIME_W+1)'(HEARTBEAT_SECONDS);

    logic signed [KARMA_W-1:0] k0;
    logic signed [KARMA_W:0]   raised;
    logic signed [KARMA_W:0]   clamped;
    logic signed [KARMA_W-1:0] k_cr;
    logic signed [KARMA_W-1:0] k1;
    logic signed [KARMA_W:0]   k_dec;
    logic                      credit;
    logic                      ended;
    logic [ALLOW_W-1:0]        allow_cur;
    logic [ALLOW_W-1:0]        allow_cr;
    logic [ALLOW_W-1:0]        allow_ch;
    logic [METER_W-1:0]        meter_sub;
    logic [METER_W-1:0]        meter1;
    logic [METER_W:0]          meter_sum;
    logic [METER_W-1:0]        meter2;

    always_comb begin
        k0     = cur.karma;
        credit = (cur.last_credit == '0) ||
                 (({1'b0, cur.last_credit} + HB) <= {1'b0, now_seconds});
        raised = {k0[KARMA_W-1], k0} + $signed({2'b00, cfg.inc_step});
        ended  = k0[KARMA_W-1] && !raised[KARMA_W];
        clamped = (raised > $signed({cfg.max_karma[KARMA_W-1], cfg.max_karma}))
                ? $signed({cfg.max_karma[KARMA_W-1], cfg.max_karma}) : raised;
        k_cr   = clamped[KARMA_W-1:0];

        allow_cur = karma_mag(k0) * cfg.bytes_per_karma;
        allow_cr  = karma_mag(k_cr) * cfg.bytes_per_karma;

        meter_sub = (cur.meter > METER_W'(allow_cr)) ? cur.meter - METER_W'(allow_cr) : '0;

        if (!credit) begin
            k1       = k0;
            meter1   = cur.meter;
            allow_ch = allow_cur;
        end else if (ended) begin
            k1       = cfg.restore_value;
            meter1   = cfg.reset_meter_en ? '0 : ((k_cr > 0) ? meter_sub : cur.meter);
            allow_ch = restore_allow;
        end else begin
            k1       = k_cr;
            meter1   = (k_cr > 0) ? meter_sub : cur.meter;
            allow_ch = allow_cr;
        end

        meter_sum = {1'b0, meter1} + (METER_W+1)'(byte_count);
        meter2    = meter_sum[METER_W] ? '1 : meter_sum[METER_W-1:0];

        k_dec = {k1[KARMA_W-1], k1} - $signed({2'b00, cfg.dec_step});

        nxt.meter       = meter2;
        nxt.last_credit = credit ? now_seconds : cur.last_credit;
        if (meter2 > METER_W'(allow_ch)) begin
            nxt.karma = (k_dec <= 0) ? cfg.penalty_value : k_dec[KARMA_W-1:0];
        end else begin
            nxt.karma = k1;
        end
        over_limit = (nxt.karma <= 0);
    end

endmodule
`default_nettype wire

### rtl/core/karma_byte_rate_limiter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// karma_byte_rate_limiter_core
// Karma-based byte-rate limiter with an APB register port.
// ----------------------------------------------------------------------------
// Takes one read-event beat per cycle while s_ready is high and presents its
// result beat from the result register once the event has passed the input
// register; result back-pressure can hold the event between the two. The
// karma, byte meter and last-credit time are updated once per event through
// one add/clamp, two 11x16 multiplies and one compare chain; that loop sets
// the throughput of one event per clock unless result beats back up. The
// input stalls only while a result beat waits and the input register is
// full. Registers sit at byte addresses 4*i; writing initial_karma also
// reloads the live karma. restore_allow_reg lags the config registers.
module karma_byte_rate_limiter_core import kbrl_pkg::*; #(
    parameter int HEARTBEAT_SECONDS = 2
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [TIME_W-1:0]         s_now_seconds,
    input  wire logic [BYTES_W-1:0]        s_byte_count,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_over_limit,
    output logic signed [KARMA_W-1:0]      m_karma_now,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [ADDR_W-1:0]         paddr,
    input  wire logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]              prdata,
    output logic                           pready
);

    logic signed [KARMA_W-1:0] initial_karma_reg;
    kbrl_cfg_t                 cfg_reg;
    logic [ALLOW_W-1:0]        restore_allow_reg;
    kbrl_state_t               state_reg;
    kbrl_state_t               state_next;

    logic                      in_valid_reg;
    logic [TIME_W-1:0]         in_now_reg;
    logic [BYTES_W-1:0]        in_bytes_reg;
    logic                      out_valid_reg;
    logic                      out_over_reg;
    logic signed [KARMA_W-1:0] out_karma_reg;

    logic                      over_next;
    logic                      fire;
    logic                      wr_en;
    kbrl_reg_t                 reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = kbrl_reg_t'(paddr[ADDR_W-1:2]);

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            initial_karma_reg       <= RST_INITIAL_KARMA;
            cfg_reg.max_karma       <= RST_MAX_KARMA;
            cfg_reg.inc_step        <= RST_INC_STEP;
            cfg_reg.dec_step        <= RST_DEC_STEP;
            cfg_reg.penalty_value   <= RST_PENALTY_VALUE;
            cfg_reg.restore_value   <= RST_RESTORE_VALUE;
            cfg_reg.reset_meter_en  <= 1'b0;
            cfg_reg.bytes_per_karma <= RST_BYTES_PER_KARMA;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_INITIAL_KARMA:   initial_karma_reg       <= pwdata[KARMA_W-1:0];
                REG_MAX_KARMA:       cfg_reg.max_karma       <= pwdata[KARMA_W-1:0];
                REG_INC_STEP:        cfg_reg.inc_step        <= pwdata[STEP_W-1:0];
                REG_DEC_STEP:        cfg_reg.dec_step        <= pwdata[STEP_W-1:0];
                REG_PENALTY_VALUE:   cfg_reg.penalty_value   <= pwdata[KARMA_W-1:0];
                REG_RESTORE_VALUE:   cfg_reg.restore_value   <= pwdata[KARMA_W-1:0];
                REG_RESET_METER_EN:  cfg_reg.reset_meter_en  <= pwdata[0];
                REG_BYTES_PER_KARMA: cfg_reg.bytes_per_karma <= pwdata[BPK_W-1:0];
            endcase
        end
    end

    // allowance of the restore value, registered from the config registers
    always_ff @(posedge aclk) begin
        restore_allow_reg <= karma_mag(cfg_reg.restore_value) * cfg_reg.bytes_per_karma;
    end

    always_comb begin
        unique case (reg_sel)
            REG_INITIAL_KARMA:   prdata = DATA_W'(initial_karma_reg);
            REG_MAX_KARMA:       prdata = DATA_W'(cfg_reg.max_karma);
            REG_INC_STEP:        prdata = DATA_W'(cfg_reg.inc_step);
            REG_DEC_STEP:        prdata = DATA_W'(cfg_reg.dec_step);
            REG_PENALTY_VALUE:   prdata = DATA_W'(cfg_reg.penalty_value);
            REG_RESTORE_VALUE:   prdata = DATA_W'(cfg_reg.restore_value);
            REG_RESET_METER_EN:  prdata = DATA_W'(cfg_reg.reset_meter_en);
            REG_BYTES_PER_KARMA: prdata = DATA_W'(cfg_reg.bytes_per_karma);
        endcase
    end

    kbrl_update #(
        .HEARTBEAT_SECONDS (HEARTBEAT_SECONDS)
    ) u_update (
        .cfg           (cfg_reg),
        .restore_allow (restore_allow_reg),
        .cur           (state_reg),
        .now_seconds   (in_now_reg),
        .byte_count    (in_bytes_reg),
        .nxt           (state_next),
        .over_limit    (over_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.karma       <= RST_INITIAL_KARMA;
            state_reg.meter       <= '0;
            state_reg.last_credit <= '0;
        end else if (wr_en && reg_sel == REG_INITIAL_KARMA) begin
            state_reg.karma <= pwdata[KARMA_W-1:0];
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_now_reg   <= s_now_seconds;
            in_bytes_reg <= s_byte_count;
        end
        if (fire) begin
            out_over_reg  <= over_next;
            out_karma_reg <= state_next.karma;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_over_limit = out_over_reg;
    assign m_karma_now  = out_karma_reg;

endmodule
`default_nettype wire

### rtl/core/kbrl_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbrl_checker
// Port-level checks for the karma byte-rate limiter.
// ----------------------------------------------------------------------------
module kbrl_checker import kbrl_pkg::*; (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_valid,
    input wire logic                      s_ready,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic                      m_over_limit,
    input wire logic signed [KARMA_W-1:0] m_karma_now
);

    // flag must agree with the reported karma
    a_flag_matches_karma: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_over_limit == (m_karma_now <= 0)))
        else $error("over_limit disagrees with karma_now");

    // input side only stalls when a result beat is stuck
    a_stall_only_on_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without output backpressure");

    // no result beat right out of reset
    a_idle_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_valid)
        else $error("result beat present right after reset");

    // a stalled result beat holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_karma_now) && $stable(m_over_limit)))
        else $error("result beat dropped or changed while stalled");

endmodule

bind karma_byte_rate_limiter_core kbrl_checker u_kbrl_checker (.*);
`default_nettype wire
